// ===== rtl/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants of the sphere/box collision test.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_RADIUS   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_X = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Y = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Z = 2'd3;

  localparam logic [15:0] ONE_Q14  = 16'd16384;
  localparam logic [14:0] ONE_Q14Q = 15'd16384;
  localparam logic [30:0] PEN_MAX  = 31'h7FFF_FFFF;

  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 15;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // classified word handed from front to back
  typedef struct packed {
    logic             far;
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][30:0] mag;
    logic [2:0][34:0] loc2;
    logic [2:0][32:0] span;
  } front_t;

  // per-item control carried down the back pipeline
  typedef struct packed {
    logic             hit;
    logic             interior;
    axis_t            axis;
    logic             aneg;
    logic [30:0]      pen;
    logic [2:0]       neg;
    logic [2:0][30:0] mag;
  } ctl_t;

endpackage

// ===== rtl/sbc_fifo.sv =====
// ----------------------------------------------------------------------------
// sbc_fifo
// Small register queue between the classify front and the compute back.
// ----------------------------------------------------------------------------
module sbc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== rtl/sbc_front.sv =====
// ----------------------------------------------------------------------------
// sbc_front
// Two-stage front: form the sphere center, clamp into the box, classify.
// ----------------------------------------------------------------------------
module sbc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [2:0][31:0]     pos,
  input  logic [2:0][31:0]     bmin,
  input  logic [2:0][31:0]     bmax,
  input  logic [2:0][31:0]     offs,
  input  logic [30:0]          radius,
  output logic                 valid_o,
  output sbc_pkg::front_t      word_o
);
  import sbc_pkg::*;

  logic        v1_r, v2_r;
  logic [32:0] c1_r  [3];
  logic [31:0] lo1_r [3];
  logic [31:0] hi1_r [3];
  front_t      word_r, word_nxt;

  logic signed [32:0] lo_s [3];
  logic signed [32:0] hi_s [3];
  logic signed [32:0] cl_a [3];
  logic signed [32:0] cl_b [3];
  logic signed [33:0] d_s  [3];
  logic        [33:0] ad   [3];
  logic signed [33:0] lohi [3];
  logic [2:0]         far_v, zero_v;

  always_comb begin
    word_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      lo_s[i] = $signed({lo1_r[i][31], lo1_r[i]});
      hi_s[i] = $signed({hi1_r[i][31], hi1_r[i]});
      cl_a[i] = ($signed(c1_r[i]) < lo_s[i]) ? lo_s[i] : $signed(c1_r[i]);
      cl_b[i] = (cl_a[i] > hi_s[i]) ? hi_s[i] : cl_a[i];
      d_s[i]  = $signed({c1_r[i][32], c1_r[i]}) - $signed({cl_b[i][32], cl_b[i]});
      ad[i]   = d_s[i][33] ? (~d_s[i] + 34'd1) : d_s[i];
      far_v[i]  = ad[i] > {3'b000, radius};
      zero_v[i] = (d_s[i] == '0);
      lohi[i] = $signed({lo_s[i][32], lo_s[i]}) + $signed({hi_s[i][32], hi_s[i]});
      word_nxt.neg[i]  = d_s[i][33];
      word_nxt.mag[i]  = ad[i][30:0];
      word_nxt.loc2[i] = {c1_r[i][32], c1_r[i], 1'b0} - {lohi[i][33], lohi[i]};
      word_nxt.span[i] = hi_s[i] - lo_s[i];
    end
    word_nxt.far  = |far_v;
    word_nxt.zero = &zero_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c1_r[i]  <= {pos[i][31], pos[i]} + {offs[i][31], offs[i]};
        lo1_r[i] <= bmin[i];
        hi1_r[i] <= bmax[i];
      end
      word_r <= word_nxt;
    end
  end

  assign valid_o = v2_r;
  assign word_o  = word_r;

endmodule

// ===== rtl/sbc_back.sv =====
// ----------------------------------------------------------------------------
// sbc_back
// Compute back: squares, face select, pipelined square root and divide.
// ----------------------------------------------------------------------------
module sbc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  sbc_pkg::front_t   q_word,
  output logic              q_pop,
  input  logic [30:0]       radius,
  input  logic              out_pop,
  output logic              out_empty,
  output logic              out_hit,
  output logic [2:0][15:0]  out_dir,
  output logic [30:0]       out_pen
);
  import sbc_pkg::*;

  logic adv;
  logic vo_r;

  assign adv   = !vo_r || out_pop;
  assign q_pop = adv && !q_empty;

  logic [61:0] rsq_r;
  always_ff @(posedge clk) begin
    rsq_r <= radius * radius;
  end

  // stage 1: registered queue head
  logic   v1_r;
  front_t e1_r;

  // stage 2: squares and face distances
  logic                v2_r;
  logic [2:0][61:0]    sq2_r;
  logic signed [35:0]  f2_r [3];
  logic [2:0]          ln2_r;
  logic                far2_r, zero2_r;
  logic [2:0]          neg2_r;
  logic [2:0][30:0]    mag2_r;

  // stage 3: squared distance, shallowest axis
  logic                v3_r;
  logic [63:0]         dsq3_r;
  logic signed [36:0]  s3_r;
  axis_t               ax3_r;
  logic                an3_r, far3_r, zero3_r;
  logic [2:0]          neg3_r;
  logic [2:0][30:0]    mag3_r;

  logic [34:0]        al   [3];
  logic signed [35:0] f_c  [3];
  axis_t              ax_c;
  logic signed [35:0] fsel;
  logic [35:0]        hpen;
  ctl_t               ctl_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      al[i]  = e1_r.loc2[i][34] ? (~e1_r.loc2[i] + 35'd1) : e1_r.loc2[i];
      f_c[i] = $signed({{3{e1_r.span[i][32]}}, e1_r.span[i]}) - $signed({1'b0, al[i]});
    end
    ax_c = AXIS_X;
    fsel = f2_r[0];
    if (f2_r[1] < fsel) begin
      ax_c = AXIS_Y;
      fsel = f2_r[1];
    end
    if (f2_r[2] < fsel) begin
      ax_c = AXIS_Z;
      fsel = f2_r[2];
    end
    hpen = s3_r[36:1];
    ctl_c.hit      = !far3_r && (zero3_r || (dsq3_r <= {2'b00, rsq_r}));
    ctl_c.interior = zero3_r;
    ctl_c.axis     = ax3_r;
    ctl_c.aneg     = an3_r;
    if (s3_r < 0) begin
      ctl_c.pen = '0;
    end else if (hpen[35:31] != '0) begin
      ctl_c.pen = PEN_MAX;
    end else begin
      ctl_c.pen = hpen[30:0];
    end
    ctl_c.neg = neg3_r;
    ctl_c.mag = mag3_r;
  end

  // square root pipeline, one result bit per stage
  logic        sv_r    [SqrtSteps+1];
  logic [63:0] sx_r    [SqrtSteps+1];
  logic [33:0] srem_r  [SqrtSteps+1];
  logic [31:0] sroot_r [SqrtSteps+1];
  ctl_t        sctl_r  [SqrtSteps+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      sv_r[0]  <= 1'b0;
    end else if (adv) begin
      v1_r     <= !q_empty;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      sv_r[0]  <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r    <= q_word;
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= e1_r.mag[i] * e1_r.mag[i];
        f2_r[i]  <= f_c[i];
        ln2_r[i] <= e1_r.loc2[i][34];
      end
      far2_r  <= e1_r.far;
      zero2_r <= e1_r.zero;
      neg2_r  <= e1_r.neg;
      mag2_r  <= e1_r.mag;
      dsq3_r  <= {2'b00, sq2_r[0]} + {2'b00, sq2_r[1]} + {2'b00, sq2_r[2]};
      ax3_r   <= ax_c;
      an3_r   <= ln2_r[ax_c];
      s3_r    <= $signed({5'b0, radius, 1'b0}) + $signed({fsel[35], fsel});
      far3_r  <= far2_r;
      zero3_r <= zero2_r;
      neg3_r  <= neg2_r;
      mag3_r  <= mag2_r;
      sx_r[0]    <= dsq3_r;
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      sctl_r[0]  <= ctl_c;
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic [35:0] rsh;
    logic [35:0] trial;
    logic        take;
    assign rsh   = {srem_r[k], sx_r[k][63:62]};
    assign trial = {2'b00, sroot_r[k], 2'b01};
    assign take  = rsh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (adv) begin
        sv_r[k+1] <= sv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sx_r[k+1]    <= {sx_r[k][61:0], 2'b00};
        srem_r[k+1]  <= take ? 34'(rsh - trial) : rsh[33:0];
        sroot_r[k+1] <= {sroot_r[k][30:0], take};
        sctl_r[k+1]  <= sctl_r[k];
      end
    end
  end

  // divide pipeline: q = (mag * 2^14 + dist/2) / dist, one bit per stage
  logic             dv_r   [DivSteps+1];
  logic [2:0][45:0] dn_r   [DivSteps+1];
  logic [2:0][14:0] dq_r   [DivSteps+1];
  logic [31:0]      ddiv_r [DivSteps+1];
  ctl_t             dctl_r [DivSteps+1];
  logic [31:0]      dist_w;
  logic [2:0][45:0] num_c;
  ctl_t             nctl_c;

  assign dist_w = sroot_r[SqrtSteps];

  always_comb begin
    nctl_c = sctl_r[SqrtSteps];
    for (int i = 0; i < 3; i++) begin
      num_c[i] = {1'b0, sctl_r[SqrtSteps].mag[i], 14'd0} + {15'd0, dist_w[31:1]};
    end
    if (!sctl_r[SqrtSteps].interior) begin
      nctl_c.pen = radius - dist_w[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= sv_r[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_r[0]   <= num_c;
      dq_r[0]   <= '0;
      ddiv_r[0] <= dist_w;
      dctl_r[0] <= nctl_c;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [46:0]      dsh;
    logic [2:0]       take;
    logic [2:0][45:0] nn;
    assign dsh = 47'(ddiv_r[j]) << (DivSteps - 1 - j);

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        take[i] = {1'b0, dn_r[j][i]} >= dsh;
        nn[i]   = take[i] ? (dn_r[j][i] - dsh[45:0]) : dn_r[j][i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dn_r[j+1]   <= nn;
        for (int i = 0; i < 3; i++) begin
          dq_r[j+1][i] <= {dq_r[j][i][13:0], take[i]};
        end
        ddiv_r[j+1] <= ddiv_r[j];
        dctl_r[j+1] <= dctl_r[j];
      end
    end
  end

  // output register: assemble the result word
  ctl_t             fc;
  logic [2:0][15:0] dir_c;
  logic [14:0]      qc;
  logic             hit_r;
  logic [2:0][15:0] dir_r;
  logic [30:0]      pen_r;

  assign fc = dctl_r[DivSteps];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc = (dq_r[DivSteps][i] > ONE_Q14Q) ? ONE_Q14Q : dq_r[DivSteps][i];
      if (!fc.hit) begin
        dir_c[i] = '0;
      end else if (fc.interior) begin
        if (fc.axis == axis_t'(i)) begin
          dir_c[i] = fc.aneg ? (~ONE_Q14 + 16'd1) : ONE_Q14;
        end else begin
          dir_c[i] = '0;
        end
      end else begin
        dir_c[i] = fc.neg[i] ? (~{1'b0, qc} + 16'd1) : {1'b0, qc};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= dv_r[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= fc.hit;
      dir_r <= dir_c;
      pen_r <= fc.hit ? fc.pen : '0;
    end
  end

  assign out_empty = !vo_r;
  assign out_hit   = hit_r;
  assign out_dir   = dir_r;
  assign out_pen   = pen_r;

endmodule

// ===== rtl/sphere_box_collision.sv =====
// Path: front, queue, back stages, square root, divide, output register.
// Throughput (out_ side not stalled): one word per cycle; the 32-step square
// root and 15-step divide are fully pipelined, so one pair enters and one
// result leaves each cycle. A 4-entry queue decouples classify and compute; a
// stalled out_ side backs up into it before in_full rises. Reset (rst_n low,
// synchronous) empties both sides and clears radius and offsets to zero.
// ----------------------------------------------------------------------------
// sphere_box_collision
// Sphere against axis-aligned box test in Q16.16 with hit, normal and depth.
// ----------------------------------------------------------------------------
module sphere_box_collision #(
  parameter int QDEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic signed [31:0]              in_pos_x,
  input  logic signed [31:0]              in_pos_y,
  input  logic signed [31:0]              in_pos_z,
  input  logic signed [31:0]              in_box_min_x,
  input  logic signed [31:0]              in_box_min_y,
  input  logic signed [31:0]              in_box_min_z,
  input  logic signed [31:0]              in_box_max_x,
  input  logic signed [31:0]              in_box_max_y,
  input  logic signed [31:0]              in_box_max_z,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_hit,
  output logic signed [15:0]              out_dir_x,
  output logic signed [15:0]              out_dir_y,
  output logic signed [15:0]              out_dir_z,
  output logic [30:0]                     out_penetration,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [31:0]                     cfg_wdata
);
  import sbc_pkg::*;

  logic [30:0]      radius_r;
  logic [2:0][31:0] off_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      off_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS:   radius_r <= cfg_wdata[30:0];
        REG_OFFSET_X: off_r[0] <= cfg_wdata;
        REG_OFFSET_Y: off_r[1] <= cfg_wdata;
        REG_OFFSET_Z: off_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic        f_adv, f_valid, q_full, q_empty, q_pop;
  front_t      f_word, q_word;
  logic [$bits(front_t)-1:0] q_rdata;
  logic [2:0][15:0] dir;

  // front holds while its last stage cannot drain into the queue
  assign f_adv   = !f_valid || !q_full;
  assign in_full = !f_adv;

  sbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (f_adv),
    .in_valid (in_push),
    .pos      ({in_pos_z, in_pos_y, in_pos_x}),
    .bmin     ({in_box_min_z, in_box_min_y, in_box_min_x}),
    .bmax     ({in_box_max_z, in_box_max_y, in_box_max_x}),
    .offs     (off_r),
    .radius   (radius_r),
    .valid_o  (f_valid),
    .word_o   (f_word)
  );

  sbc_fifo #(
    .W     ($bits(front_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .wdata (f_word),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_word = front_t'(q_rdata);

  sbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .radius    (radius_r),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_hit   (out_hit),
    .out_dir   (dir),
    .out_pen   (out_penetration)
  );

  assign out_dir_x = dir[0];
  assign out_dir_y = dir[1];
  assign out_dir_z = dir[2];

`ifndef SYNTHESIS
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_hit) |-> (out_dir_x == 0 && out_dir_y == 0 &&
                                  out_dir_z == 0 && out_penetration == 0))
    else $error("miss result carries nonzero direction or depth");

  a_dir_range : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_dir_x <= 16'sd16384 && out_dir_x >= -16'sd16384 &&
                    out_dir_y <= 16'sd16384 && out_dir_y >= -16'sd16384 &&
                    out_dir_z <= 16'sd16384 && out_dir_z >= -16'sd16384))
    else $error("direction component beyond unit");

  a_hit_dir : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_hit) |-> (out_dir_x != 0 || out_dir_y != 0 || out_dir_z != 0))
    else $error("hit result without a direction");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Sphere/box collision check: a directed table, then random boxes and spheres
// around them, pushed in bursts against a stalling reader; every word that
// comes out is compared to its table row or a local Q16.16 collision model.
// ----------------------------------------------------------------------------
module tb;
  import sbc_pkg::*;

  typedef struct packed {
    logic signed [31:0] px, py, pz, lx, ly, lz, hx, hy, hz;
  } pair_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] dx, dy, dz;
    logic [30:0] pen;
  } contact_t;

  typedef struct {
    pair_t    p;
    logic     known;
    contact_t c;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  pair_t in_w = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_hit;
  logic signed [15:0] out_dir_x, out_dir_y, out_dir_z;
  logic [30:0] out_penetration;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  logic [30:0] radius;
  logic signed [31:0] offs [3];
  contact_t contacts_due [$];
  int mismatches = 0;
  int stall_mode = 0;

  sphere_box_collision uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_pos_x(in_w.px), .in_pos_y(in_w.py), .in_pos_z(in_w.pz),
    .in_box_min_x(in_w.lx), .in_box_min_y(in_w.ly), .in_box_min_z(in_w.lz),
    .in_box_max_x(in_w.hx), .in_box_max_y(in_w.hy), .in_box_max_z(in_w.hz),
    .out_empty(out_empty), .out_pop(out_pop), .out_hit(out_hit),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z),
    .out_penetration(out_penetration),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic contact_t sphere_vs_box(pair_t p);
    contact_t o;
    longint c[3], lo[3], hi[3], d[3], loc2[3], face2[3], dir[3], cl, s, mag;
    longint unsigned dsq, dist_v, q;
    longint r;
    logic far;
    int axis;
    r = longint'(radius);
    far = 1'b0;
    dsq = 0;
    c[0] = longint'(p.px) + offs[0];
    c[1] = longint'(p.py) + offs[1];
    c[2] = longint'(p.pz) + offs[2];
    lo[0] = p.lx; lo[1] = p.ly; lo[2] = p.lz;
    hi[0] = p.hx; hi[1] = p.hy; hi[2] = p.hz;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      dir[i] = 0;
      cl = c[i] < lo[i] ? lo[i] : c[i];
      if (cl > hi[i]) cl = hi[i];
      d[i] = c[i] - cl;
      if ((d[i] < 0 ? -d[i] : d[i]) > r) far = 1'b1;
    end
    if (!far) begin
      for (int i = 0; i < 3; i++) dsq += longint'(d[i] * d[i]);
      if (dsq != 0) begin
        if (dsq <= longint'(r * r)) begin
          dist_v = floor_sqrt(dsq);
          o.hit = 1'b1;
          for (int i = 0; i < 3; i++) begin
            mag = d[i] < 0 ? -d[i] : d[i];
            q = (longint'(mag) * 16384 + dist_v / 2) / dist_v;
            if (q > 16384) q = 16384;
            dir[i] = d[i] < 0 ? -longint'(q) : longint'(q);
          end
          o.pen = 31'(longint'(r) - longint'(dist_v));
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          loc2[i] = 2 * c[i] - (lo[i] + hi[i]);
          face2[i] = (hi[i] - lo[i]) - (loc2[i] < 0 ? -loc2[i] : loc2[i]);
        end
        axis = 0;
        if (face2[1] < face2[0]) axis = 1;
        if (face2[2] < face2[axis]) axis = 2;
        dir[axis] = loc2[axis] >= 0 ? 16384 : -16384;
        s = 2 * r + face2[axis];
        if (s < 0) s = 0;
        s = s >>> 1;
        if (s > 64'h7FFF_FFFF) s = 64'h7FFF_FFFF;
        o.pen = 31'(s);
        o.hit = 1'b1;
      end
    end
    o.dx = 16'(dir[0]);
    o.dy = 16'(dir[1]);
    o.dz = 16'(dir[2]);
    return o;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RADIUS:   radius = val[30:0];
      REG_OFFSET_X: offs[0] = val;
      REG_OFFSET_Y: offs[1] = val;
      default:      offs[2] = val;
    endcase
  endtask

  task automatic set_sphere(logic [30:0] r, logic [31:0] ox, logic [31:0] oy,
                            logic [31:0] oz);
    while (contacts_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    write_reg(REG_RADIUS, {1'b0, r});
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
  endtask

  // hold the word until accepted; a following push keeps in_push high
  task automatic push_pair(pair_t p, logic known, contact_t c);
    contact_t m;
    m = sphere_vs_box(p);
    if (known && m != c)
      $display("directed row disagrees with model: %h vs %h", c, m);
    in_w <= p;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    contacts_due.push_back(known ? c : m);
    if ($urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic pause_push();
    in_push <= 1'b0;
  endtask

  function automatic logic signed [31:0] rnd_span();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000);
      2: return $urandom_range(0, 255);
      default: return 32'(int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000);
    endcase
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    logic signed [31:0] a, b;
    logic signed [31:0] lo[3], hi[3], ps[3];
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        lo[i] = $urandom;
        hi[i] = $urandom;
        ps[i] = $urandom;
      end else begin
        a = rnd_span();
        b = 32'(int'($urandom_range(0, 32'h0008_0000)));
        lo[i] = a;
        hi[i] = a + b;
        // place center near the box, with offset removed
        ps[i] = a + 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'h0004_0000)
                - offs[i];
      end
    end
    p.px = ps[0]; p.py = ps[1]; p.pz = ps[2];
    p.lx = lo[0]; p.ly = lo[1]; p.lz = lo[2];
    p.hx = hi[0]; p.hy = hi[1]; p.hz = hi[2];
    return p;
  endfunction

  // reader: pattern changes per phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= ($urandom_range(0, 3) != 0);
        default: out_pop <= ($urandom_range(0, 4) == 0);
      endcase
      if (out_pop && !out_empty) begin
        if (contacts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: hit=%0d dir=%0d/%0d/%0d pen=%h",
                     out_hit, out_dir_x, out_dir_y, out_dir_z, out_penetration);
        end else begin
          contact_t e;
          e = contacts_due.pop_front();
          if (out_hit !== e.hit || out_dir_x !== e.dx || out_dir_y !== e.dy ||
              out_dir_z !== e.dz || out_penetration !== e.pen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit=%0d dir=%0d/%0d/%0d pen=%h, got hit=%0d dir=%0d/%0d/%0d pen=%h",
                       e.hit, $signed(e.dx), $signed(e.dy), $signed(e.dz), e.pen,
                       out_hit, out_dir_x, out_dir_y, out_dir_z, out_penetration);
          end
        end
      end
    end
  end

  localparam logic signed [31:0] ONE = 32'h0001_0000;
  localparam logic signed [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'h8000_0000;

  initial begin
    row_t tbl [$];
    contact_t nohit;
    radius = '0;
    offs[0] = '0; offs[1] = '0; offs[2] = '0;
    nohit = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // radius zero after reset: center inside unit box, on a face, outside; inverted box
    tbl.push_back('{'{0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b1,
                   '{1'b1, 16'd16384, 16'd0, 16'd0, 31'h0001_0000}});
    tbl.push_back('{'{ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b1,
                   '{1'b1, 16'd16384, 16'd0, 16'd0, 31'd0}});
    tbl.push_back('{'{2 * ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b1, nohit});
    tbl.push_back('{'{SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN}, 1'b0, nohit});
    foreach (tbl[k]) push_pair(tbl[k].p, tbl[k].known, tbl[k].c);
    pause_push();

    set_sphere(31'h0002_0000, 32'h0, 32'h0, 32'h0);
    tbl.delete();
    // sphere just touching a face on one axis, a miss, x, y and z shallowest,
    // corner, and an inverted box
    tbl.push_back('{'{3 * ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b1,
                   '{1'b1, 16'd16384, 16'd0, 16'd0, 31'd0}});
    tbl.push_back('{'{0, -3 * ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b1,
                   '{1'b1, 16'd0, -16'sd16384, 16'd0, 31'd0}});
    tbl.push_back('{'{0, 0, 4 * ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b1, nohit});
    tbl.push_back('{'{0, 0, 0, -ONE, -4 * ONE, -4 * ONE, ONE, 4 * ONE, 4 * ONE}, 1'b0, nohit});
    tbl.push_back('{'{0, 0, 0, -4 * ONE, -ONE, -4 * ONE, 4 * ONE, ONE, 4 * ONE}, 1'b0, nohit});
    tbl.push_back('{'{0, 0, -ONE / 2, -4 * ONE, -4 * ONE, -ONE, 4 * ONE, 4 * ONE, ONE},
                   1'b0, nohit});
    tbl.push_back('{'{2 * ONE, 2 * ONE, 2 * ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b0, nohit});
    tbl.push_back('{'{ONE + 5, ONE + 3, -ONE - 7, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1'b0, nohit});
    tbl.push_back('{'{0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE}, 1'b0, nohit});
    foreach (tbl[k]) push_pair(tbl[k].p, tbl[k].known, tbl[k].c);
    pause_push();

    // extremes: largest radius, extreme offsets push the center to 33 bits
    set_sphere(31'h7FFF_FFFF, SMAX, SMIN, SMAX);
    tbl.delete();
    tbl.push_back('{'{SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX}, 1'b0, nohit});
    tbl.push_back('{'{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX}, 1'b0, nohit});
    tbl.push_back('{'{0, 0, 0, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX}, 1'b0, nohit});
    tbl.push_back('{'{SMIN, SMAX, SMIN, 0, 0, 0, 0, 0, 0}, 1'b0, nohit});
    tbl.push_back('{'{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                      32'sd0, 32'sd0, 32'sd0}, 1'b0, nohit});
    foreach (tbl[k]) push_pair(tbl[k].p, tbl[k].known, tbl[k].c);
    pause_push();

    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      case (ph)
        0: set_sphere(31'h0000_8000, 32'h0, 32'h0, 32'h0);
        1: set_sphere(31'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0003);
        2: set_sphere(31'h7FFF_FFFF, $urandom, $urandom, $urandom);
        3: set_sphere(31'd1, 32'h0, 32'h0, 32'h0);
        4: set_sphere(31'($urandom), $urandom, $urandom, $urandom);
        default: set_sphere(31'($urandom_range(0, 32'h0008_0000)),
                            $urandom_range(0, 32'h10_0000), 32'h0, 32'hFFF0_0000);
      endcase
      for (int n = 0; n < 90; n++) begin
        pair_t p;
        p = rnd_pair();
        push_pair(p, 1'b0, nohit);
        if ($urandom_range(0, 19) == 0) begin
          pause_push();
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
      end
      pause_push();
    end

    stall_mode = 0;
    while (contacts_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sbc_pkg.sv
rtl/sbc_fifo.sv
rtl/sbc_front.sv
rtl/sbc_back.sv
rtl/sphere_box_collision.sv
tb/tb.sv
